// File: rtl/core/ale_pkg.sv
// ale_pkg: sizes, request and status codes for the array list engine
// no dependencies; imported by ale_mem and array_list_engine_unit
package ale_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ACT_W      = 3;
  localparam int POS_W      = 7;
  localparam int STAT_W     = 2;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // request codes
  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_AT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INDEX_OF = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  localparam cnt_t DEPTH_C = cnt_t'(DEPTH);

endpackage

// File: rtl/core/ale_mem.sv
// ale_mem: entry store, one write port and one read port, registered read
// depends on ale_pkg for entry and index types
module ale_mem
  import ale_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  idx_t  waddr,
  input  item_t wdata,
  input  idx_t  raddr,
  output item_t rdata
);

  item_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/array_list_engine_unit.sv
// array_list_engine_unit: dense ordered list with append, write, search, get and delete
// depends on ale_pkg and ale_mem
//
//   channel  direction  handshake             payload
//   request  in         in_valid / in_ready   action, position, item_value
//   result   out        out_valid / out_ready status, found, found_index, read_value, length
//
// One item at a time. Append, write-at and error cases finish in S_EXEC, get reads in S_GET.
// Index-of walks at most the whole list: the scan reads one entry per cycle
// through the single read port and compares it the cycle after.
// Delete-at and remove-value then shift the later entries down, one
// read and one write per cycle. Reset clears the length and the control state only.
// A new item is taken while the last result still waits at the output register.
module array_list_engine_unit
  import ale_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [POS_W-1:0]  position,
  input  logic [31:0]       item_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic              found,
  output logic [5:0]        found_index,
  output logic [31:0]       read_value,
  output logic [6:0]        length
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_GET   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  cnt_t   count, count_next;
  cnt_t   ri, ri_next;
  idx_t   ci, ci_next;
  logic   pend, pend_next;

  logic [ACT_W-1:0]  req_action;
  logic [POS_W-1:0]  req_pos;
  item_t             req_value;

  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_found, res_found_next;
  idx_t              res_index, res_index_next;
  item_t             res_value, res_value_next;

  logic  mem_we;
  idx_t  mem_waddr;
  item_t mem_wdata;
  idx_t  mem_raddr;
  item_t mem_rdata;
  logic  issue;
  logic  out_free;

  ale_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign issue    = (ri < count);

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action <= action;
      req_pos    <= position;
      req_value  <= item_t'(item_value);
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    ri_next         = ri;
    ci_next         = ci;
    pend_next       = pend;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_index_next  = res_index;
    res_value_next  = res_value;
    mem_we          = 1'b0;
    mem_waddr       = count[IDX_W-1:0];
    mem_wdata       = req_value;
    mem_raddr       = ri[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_next = ST_OK;
        res_found_next  = 1'b0;
        res_index_next  = '0;
        res_value_next  = '0;
        state_next      = S_DONE;
        case (req_action)
          ACT_APPEND, ACT_WRITE_AT: begin
            if (req_action == ACT_WRITE_AT && cnt_t'(req_pos) > count) begin
              res_status_next = ST_BAD_POS;
            end else if (req_action == ACT_WRITE_AT && cnt_t'(req_pos) < count) begin
              // overwrite in place
              mem_we    = 1'b1;
              mem_waddr = req_pos[IDX_W-1:0];
            end else if (count == DEPTH_C) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              count_next = count + cnt_t'(1);
            end
          end
          ACT_INDEX_OF, ACT_REMOVE: begin
            ri_next    = '0;
            pend_next  = 1'b0;
            state_next = S_SCAN;
          end
          ACT_GET: begin
            if (cnt_t'(req_pos) >= count) begin
              res_status_next = ST_NOT_FOUND;
            end else begin
              mem_raddr  = req_pos[IDX_W-1:0];
              state_next = S_GET;
            end
          end
          ACT_DELETE: begin
            if (cnt_t'(req_pos) >= count) begin
              res_status_next = ST_NOT_FOUND;
            end else begin
              ri_next    = cnt_t'(req_pos) + cnt_t'(1);
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
          end
          default: begin
            res_status_next = ST_BAD_POS;
          end
        endcase
      end

      S_GET: begin
        res_value_next = mem_rdata;
        state_next     = S_DONE;
      end

      // read one entry per cycle, compare the previous read
      S_SCAN: begin
        if (pend && mem_rdata == req_value) begin
          res_found_next = 1'b1;
          res_index_next = ci;
          if (req_action == ACT_REMOVE) begin
            ri_next    = cnt_t'(ci) + cnt_t'(1);
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end else if (!issue && !pend) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          if (issue) begin
            ri_next = ri + cnt_t'(1);
            ci_next = ri[IDX_W-1:0];
          end
          pend_next = issue;
        end
      end

      // move each later entry down by one slot
      S_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = ci - idx_t'(1);
          mem_wdata = mem_rdata;
        end
        if (issue) begin
          ri_next = ri + cnt_t'(1);
          ci_next = ri[IDX_W-1:0];
        end
        pend_next = issue;
        if (!issue && !pend) begin
          count_next = count - cnt_t'(1);
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ri         <= ri_next;
    ci         <= ci_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_index  <= res_index_next;
    res_value  <= res_value_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      found       <= res_found;
      found_index <= 6'(res_index);
      read_value  <= 32'(res_value);
      length      <= 7'(count);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("length beyond depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT) |-> ri <= count)
    else $error("walk index past length");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_EXEC || state == S_SHIFT))
    else $error("entry write outside exec or shift");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted item not executed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC && state != S_SHIFT) |=> $stable(count))
    else $error("length changed outside exec or shift");

endmodule
